>>> design/si_descriptor_loop_parser_assert.svh
// Assertion macros shared by the checker of the descriptor loop parser.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SI_DESCRIPTOR_LOOP_PARSER_ASSERT_SVH
`define SI_DESCRIPTOR_LOOP_PARSER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SIDLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SIDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sidlp_pkg.sv
package sidlp_pkg;

    // Parser phases within one descriptor.
    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_LEN   = 3'd1,
        PH_SKIP  = 3'd2,
        PH_FIXED = 3'd3,
        PH_STRA  = 3'd4,
        PH_LENB  = 3'd5,
        PH_STRB  = 3'd6,
        PH_DONE  = 3'd7
    } sidlp_phase_t;

    // Wanted descriptor kinds.
    localparam logic [2:0] KIND_SERVICE   = 3'd0;
    localparam logic [2:0] KIND_EVENT     = 3'd1;
    localparam logic [2:0] KIND_NETWORK   = 3'd2;
    localparam logic [2:0] KIND_SATELLITE = 3'd3;
    localparam logic [2:0] KIND_SVC_LIST  = 3'd4;

    // Field identifiers of the result items.
    localparam logic [4:0] FID_POSITION   = 5'd0;
    localparam logic [4:0] FID_TAG        = 5'd1;
    localparam logic [4:0] FID_LENGTH     = 5'd2;
    localparam logic [4:0] FID_SVC_TYPE   = 5'd3;
    localparam logic [4:0] FID_PROV_LEN   = 5'd4;
    localparam logic [4:0] FID_EVENT_LANG = 5'd8;
    localparam logic [4:0] FID_EVENT_NLEN = 5'd9;
    localparam logic [4:0] FID_NET_NAME   = 5'd13;
    localparam logic [4:0] FID_FREQUENCY  = 5'd14;
    localparam logic [4:0] FID_ORBITAL    = 5'd15;
    localparam logic [4:0] FID_WEST_EAST  = 5'd16;
    localparam logic [4:0] FID_POLARISE   = 5'd17;
    localparam logic [4:0] FID_ROLL_OFF   = 5'd18;
    localparam logic [4:0] FID_MOD_SYSTEM = 5'd19;
    localparam logic [4:0] FID_MOD_TYPE   = 5'd20;
    localparam logic [4:0] FID_SYM_RATE   = 5'd21;
    localparam logic [4:0] FID_FEC_INNER  = 5'd22;
    localparam logic [4:0] FID_LIST_SID   = 5'd23;
    localparam logic [4:0] FID_LIST_TYPE  = 5'd24;
    localparam logic [4:0] FID_STATUS     = 5'd25;

    // Results one input byte can cause, and queue depth in bundles.
    localparam int MAX_RESULTS = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [6:0] ENTRY_MAX = 7'h7F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       loop_start;
        logic       loop_end;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_id;
        logic [31:0] field_value;
        logic        not_found;
        logic        last_result;
    } out_item_t;

    // All results caused by one input byte, in order.
    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] res;
        logic [2:0]                  count;
    } sidlp_bundle_t;

    // True when the byte is the tag of the wanted kind.
    function automatic logic tag_match(input logic [2:0] kind, input logic [7:0] b);
        logic m;
        begin
            unique case (kind)
                KIND_SERVICE:   m = (b == 8'h48);
                KIND_EVENT:     m = (b == 8'h4d);
                KIND_NETWORK:   m = (b == 8'h40);
                KIND_SATELLITE: m = (b == 8'h43);
                KIND_SVC_LIST:  m = (b == 8'h41);
                default:        m = 1'b0;
            endcase
            return m;
        end
    endfunction

endpackage

>>> design/si_descriptor_loop_parser.sv
// A result item is registered in a queue slot and then in the output hold register.
// Throughput: one input item per cycle while each causes at most one result item and
// out_ready stays high; the output side sends one result item per cycle while ready,
// and a four-bundle queue absorbs bytes that cause several. Reset clears the parser,
// the queue and kind_reg (service) at once; no clearing pass is needed.
module si_descriptor_loop_parser #(
    parameter int MAX_LOOP_BYTES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sidlp_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sidlp_pkg::out_item_t out_item
);

    logic [2:0] kind_reg;
    logic       push, queue_ready, pop, pop_valid;
    sidlp_pkg::sidlp_bundle_t push_bundle, pop_bundle;

    // Wanted descriptor kind register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= sidlp_pkg::KIND_SERVICE;
        else if (cfg_wr_en)
            kind_reg <= cfg_wr_data;
    end

    sidlp_front #(
        .MAX_LOOP_BYTES(MAX_LOOP_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .push        (push),
        .push_bundle (push_bundle),
        .queue_ready (queue_ready)
    );

    sidlp_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .push_ready  (queue_ready),
        .pop         (pop),
        .pop_bundle  (pop_bundle),
        .pop_valid   (pop_valid)
    );

    sidlp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_bundle (pop_bundle),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

>>> design/sidlp_front.sv
module sidlp_front #(
    parameter int MAX_LOOP_BYTES = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [2:0]               kind,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sidlp_pkg::in_item_t      in_item,
    output logic                     push,
    output sidlp_pkg::sidlp_bundle_t push_bundle,
    input  logic                     queue_ready
);

    localparam int OFF_W = $clog2(MAX_LOOP_BYTES + 1);
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(MAX_LOOP_BYTES);

    sidlp_pkg::sidlp_phase_t phase_reg, phase_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [7:0]       bid_reg, bid_next;
    logic [7:0]       dlen_reg, dlen_next;
    logic [7:0]       srem_reg, srem_next;
    logic [31:0]      acc_reg, acc_next;
    logic [6:0]       ecnt_reg, ecnt_next;
    logic             found_reg, found_next;
    logic             accept;

    assign in_ready = queue_ready;
    assign accept   = in_valid && queue_ready;
    assign push     = accept && (push_bundle.count != 3'd0);

    // Parse one byte and collect the results it causes.
    always_comb
    begin
        sidlp_pkg::sidlp_phase_t ph;
        logic [OFF_W-1:0] off;
        logic [7:0]  bid, dlen, srem, b;
        logic [31:0] acc, acc_old;
        logic [6:0]  ecnt;
        logic        fnd;
        logic [2:0]  n;
        logic [4:0]  base;
        logic        body;

        ph   = phase_reg;
        off  = offset_reg;
        bid  = bid_reg;
        dlen = dlen_reg;
        srem = srem_reg;
        acc  = acc_reg;
        ecnt = ecnt_reg;
        fnd  = found_reg;
        b    = in_item.data_byte;
        n    = 3'd0;
        base = (kind == sidlp_pkg::KIND_EVENT) ? 5'd9 : 5'd4;
        body = 1'b0;
        acc_old = acc_reg;
        push_bundle = '0;

        // A new loop clears the loop state before the byte is parsed.
        if (in_item.loop_start)
        begin
            ph = sidlp_pkg::PH_TAG; off = '0; bid = '0; dlen = '0;
            srem = '0; acc = '0; ecnt = '0; fnd = 1'b0;
        end
        acc_old = acc;

        if (off < OFF_LIMIT)
        begin
            unique case (ph)
                sidlp_pkg::PH_TAG:
                begin
                    if (sidlp_pkg::tag_match(kind, b))
                    begin
                        fnd = 1'b1;
                        push_bundle.res[n] = {sidlp_pkg::FID_POSITION, 32'(off), 2'b00};
                        n = n + 3'd1;
                        push_bundle.res[n] = {sidlp_pkg::FID_TAG, 24'd0, b, 2'b00};
                        n = n + 3'd1;
                    end
                    ph = sidlp_pkg::PH_LEN;
                end
                sidlp_pkg::PH_LEN:
                begin
                    dlen = b; bid = '0; srem = '0; acc = '0;
                    if (fnd)
                    begin
                        push_bundle.res[n] = {sidlp_pkg::FID_LENGTH, 24'd0, b, 2'b00};
                        n = n + 3'd1;
                    end
                    if (b == 8'd0)
                        ph = fnd ? sidlp_pkg::PH_DONE : sidlp_pkg::PH_TAG;
                    else
                        ph = fnd ? sidlp_pkg::PH_FIXED : sidlp_pkg::PH_SKIP;
                end
                sidlp_pkg::PH_DONE:
                begin
                    ph = sidlp_pkg::PH_DONE;
                end
                sidlp_pkg::PH_FIXED:
                begin
                    body = 1'b1;
                    unique case (kind)
                        sidlp_pkg::KIND_SERVICE:
                        begin
                            if (bid == 8'd0)
                            begin
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_SVC_TYPE, 24'd0, b, 2'b00};
                                n = n + 3'd1;
                            end
                            else if (bid == 8'd1)
                            begin
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_PROV_LEN, 24'd0, b, 2'b00};
                                n = n + 3'd1;
                                srem = b;
                                ph = (b != 8'd0) ? sidlp_pkg::PH_STRA : sidlp_pkg::PH_LENB;
                            end
                        end
                        sidlp_pkg::KIND_EVENT:
                        begin
                            if (bid == 8'd0)
                                acc = {24'd0, b};
                            else if (bid <= 8'd2)
                                acc = {acc_old[23:0], b};
                            if (bid == 8'd2)
                            begin
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_EVENT_LANG, 8'd0, acc[23:0], 2'b00};
                                n = n + 3'd1;
                            end
                            else if (bid == 8'd3)
                            begin
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_EVENT_NLEN, 24'd0, b, 2'b00};
                                n = n + 3'd1;
                                srem = b;
                                ph = (b != 8'd0) ? sidlp_pkg::PH_STRA : sidlp_pkg::PH_LENB;
                            end
                        end
                        sidlp_pkg::KIND_NETWORK:
                        begin
                            push_bundle.res[n] = {sidlp_pkg::FID_NET_NAME, 24'd0, b, 2'b00};
                            n = n + 3'd1;
                        end
                        sidlp_pkg::KIND_SATELLITE:
                        begin
                            if (bid == 8'd0 || bid == 8'd4 || bid == 8'd7)
                                acc = {24'd0, b};
                            else if (bid < 8'd10 && bid != 8'd6)
                                acc = {acc_old[23:0], b};
                            if (bid == 8'd3)
                            begin
                                push_bundle.res[n] = {sidlp_pkg::FID_FREQUENCY, acc, 2'b00};
                                n = n + 3'd1;
                            end
                            else if (bid == 8'd5)
                            begin
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_ORBITAL, 16'd0, acc[15:0], 2'b00};
                                n = n + 3'd1;
                            end
                            else if (bid == 8'd6)
                            begin
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_WEST_EAST, 31'd0, b[7], 2'b00};
                                n = n + 3'd1;
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_POLARISE, 30'd0, b[6:5], 2'b00};
                                n = n + 3'd1;
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_ROLL_OFF, 30'd0, b[4:3], 2'b00};
                                n = n + 3'd1;
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_MOD_SYSTEM, 31'd0, b[2], 2'b00};
                                n = n + 3'd1;
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_MOD_TYPE, 30'd0, b[1:0], 2'b00};
                                n = n + 3'd1;
                            end
                            else if (bid == 8'd10)
                            begin
                                push_bundle.res[n] = {sidlp_pkg::FID_SYM_RATE, 4'd0,
                                                      acc_old[23:0], b[7:4], 2'b00};
                                n = n + 3'd1;
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_FEC_INNER, 28'd0, b[3:0], 2'b00};
                                n = n + 3'd1;
                            end
                        end
                        sidlp_pkg::KIND_SVC_LIST:
                        begin
                            if (srem == 8'd0)
                            begin
                                acc = {24'd0, b};
                                srem = 8'd1;
                            end
                            else if (srem == 8'd1)
                            begin
                                acc = {acc_old[23:0], b};
                                srem = 8'd2;
                            end
                            else
                            begin
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_LIST_SID, 16'd0, acc_old[15:0], 2'b00};
                                n = n + 3'd1;
                                push_bundle.res[n] =
                                    {sidlp_pkg::FID_LIST_TYPE, 24'd0, b, 2'b00};
                                n = n + 3'd1;
                                if (ecnt != sidlp_pkg::ENTRY_MAX)
                                    ecnt = ecnt + 7'd1;
                                srem = 8'd0;
                            end
                        end
                        default:
                        begin
                            acc = acc_old;
                        end
                    endcase
                end
                sidlp_pkg::PH_STRA:
                begin
                    body = 1'b1;
                    push_bundle.res[n] = {base + 5'd1, 24'd0, b, 2'b00};
                    n = n + 3'd1;
                    srem = srem - 8'd1;
                    if (srem == 8'd0)
                        ph = sidlp_pkg::PH_LENB;
                end
                sidlp_pkg::PH_LENB:
                begin
                    body = 1'b1;
                    push_bundle.res[n] = {base + 5'd2, 24'd0, b, 2'b00};
                    n = n + 3'd1;
                    srem = b;
                    ph = (b != 8'd0) ? sidlp_pkg::PH_STRB : sidlp_pkg::PH_SKIP;
                end
                sidlp_pkg::PH_STRB:
                begin
                    body = 1'b1;
                    push_bundle.res[n] = {base + 5'd3, 24'd0, b, 2'b00};
                    n = n + 3'd1;
                    srem = srem - 8'd1;
                    if (srem == 8'd0)
                        ph = sidlp_pkg::PH_SKIP;
                end
                sidlp_pkg::PH_SKIP:
                begin
                    body = 1'b1;
                end
                default:
                begin
                    body = 1'b0;
                end
            endcase

            // Body bytes advance the position inside the descriptor.
            if (body)
            begin
                bid = bid + 8'd1;
                if (bid >= dlen)
                    ph = fnd ? sidlp_pkg::PH_DONE : sidlp_pkg::PH_TAG;
            end
            off = off + OFF_W'(1);
        end

        // The last byte of a loop adds the status and clears the loop state.
        if (in_item.loop_end)
        begin
            push_bundle.res[n] = {sidlp_pkg::FID_STATUS, 25'd0, ecnt, !fnd, 1'b1};
            n = n + 3'd1;
            ph = sidlp_pkg::PH_TAG; off = '0; bid = '0; dlen = '0;
            srem = '0; acc = '0; ecnt = '0; fnd = 1'b0;
        end

        push_bundle.count = n;
        phase_next  = ph;
        offset_next = off;
        bid_next    = bid;
        dlen_next   = dlen;
        srem_next   = srem;
        acc_next    = acc;
        ecnt_next   = ecnt;
        found_next  = fnd;
    end

    // Parser state advances on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sidlp_pkg::PH_TAG;
            offset_reg <= '0;
            bid_reg    <= '0;
            dlen_reg   <= '0;
            srem_reg   <= '0;
            acc_reg    <= '0;
            ecnt_reg   <= '0;
            found_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            bid_reg    <= bid_next;
            dlen_reg   <= dlen_next;
            srem_reg   <= srem_next;
            acc_reg    <= acc_next;
            ecnt_reg   <= ecnt_next;
            found_reg  <= found_next;
        end
    end

endmodule

>>> design/sidlp_queue.sv
module sidlp_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  sidlp_pkg::sidlp_bundle_t push_bundle,
    output logic                     push_ready,
    input  logic                     pop,
    output sidlp_pkg::sidlp_bundle_t pop_bundle,
    output logic                     pop_valid
);

    localparam int PTR_W = $clog2(sidlp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sidlp_pkg::QUEUE_DEPTH + 1);

    sidlp_pkg::sidlp_bundle_t slot_reg [sidlp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(sidlp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_bundle = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Fill level follows pushes and pops.
    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CNT_W'(1);
    end

    // Bundle storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_bundle;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fill_reg <= fill_next;
        end
    end

endmodule

>>> design/sidlp_back.sv
module sidlp_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pop_valid,
    input  sidlp_pkg::sidlp_bundle_t pop_bundle,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sidlp_pkg::out_item_t     out_item
);

    sidlp_pkg::sidlp_bundle_t hold_reg;
    logic [2:0] idx_reg;
    logic       valid_reg;
    logic       taken, last;

    assign out_valid = valid_reg;
    assign out_item  = hold_reg.res[idx_reg];
    assign taken     = valid_reg && out_ready;
    assign last      = (idx_reg == hold_reg.count - 3'd1);
    assign pop       = pop_valid && (!valid_reg || (taken && last));

    // Bundle being sent out, one result item per cycle while out_ready is high.
    always_ff @(posedge clk)
    begin
        if (pop)
            hold_reg <= pop_bundle;
    end

    // Result index and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b1;
        end
        else if (taken && last)
        begin
            valid_reg <= 1'b0;
        end
        else if (taken)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

endmodule

>>> design/sidlp_checker.sv
`include "si_descriptor_loop_parser_assert.svh"

module sidlp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input sidlp_pkg::out_item_t out_item
);

    // The final status and only it carries the last mark.
    `SIDLP_ASSERT_NOW(status_is_last, out_valid, ((out_item.field_id == sidlp_pkg::FID_STATUS) == out_item.last_result), "status and last mark disagree")

    // Only the status may report a missing descriptor.
    `SIDLP_ASSERT_NOW(nf_on_status, out_valid && !out_item.last_result, !out_item.not_found, "not found outside status")

    // Field identifiers stay within the defined set.
    `SIDLP_ASSERT_NOW(fid_range, out_valid, out_item.field_id <= sidlp_pkg::FID_STATUS, "field id out of range")

    // A stalled result item holds.
    `SIDLP_ASSERT_NEXT(out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled item changed")

endmodule

bind si_descriptor_loop_parser sidlp_checker u_sidlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

>>> sim/tb_si_descriptor_loop_parser.sv
module tb_si_descriptor_loop_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LOOP_BYTES = 4096;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int TOTAL_ITEMS    = 220;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_LOOP      = 8;
    localparam int PAUSE_LOOP     = 9;

    localparam logic [7:0] TAG_SERVICE   = 8'h48;
    localparam logic [7:0] TAG_EVENT     = 8'h4d;
    localparam logic [7:0] TAG_NETWORK   = 8'h40;
    localparam logic [7:0] TAG_SATELLITE = 8'h43;
    localparam logic [7:0] TAG_SVC_LIST  = 8'h41;

    // Field decoder model: follows the tag/length chain and queues the expected fields.
    class field_scoreboard;
        sidlp_pkg::out_item_t    expected_fields[$];
        int                      errors;
        int                      checked;
        logic [2:0]              kind;
        sidlp_pkg::sidlp_phase_t phase;
        int unsigned             offset;
        logic [7:0]              byte_idx;
        logic [7:0]              desc_len;
        logic [7:0]              str_left;
        logic [31:0]             acc;
        logic [6:0]              entries;
        logic                    found;

        function new();
            errors  = 0;
            checked = 0;
            kind    = sidlp_pkg::KIND_SERVICE;
            clear_loop();
        endfunction

        function void clear_loop();
            phase    = sidlp_pkg::PH_TAG;
            offset   = 0;
            byte_idx = '0;
            desc_len = '0;
            str_left = '0;
            acc      = '0;
            entries  = '0;
            found    = 1'b0;
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        function void add(logic [4:0] id, logic [31:0] v);
            sidlp_pkg::out_item_t r;
            r.field_id    = id;
            r.field_value = v;
            r.not_found   = 1'b0;
            r.last_result = 1'b0;
            expected_fields.push_back(r);
        endfunction

        function logic kind_tag_hit(logic [7:0] b);
            case (kind)
                sidlp_pkg::KIND_SERVICE:   return b == TAG_SERVICE;
                sidlp_pkg::KIND_EVENT:     return b == TAG_EVENT;
                sidlp_pkg::KIND_NETWORK:   return b == TAG_NETWORK;
                sidlp_pkg::KIND_SATELLITE: return b == TAG_SATELLITE;
                sidlp_pkg::KIND_SVC_LIST:  return b == TAG_SVC_LIST;
                default:                   return 1'b0;
            endcase
        endfunction

        // A string length byte: emit it and move on to the string or the next length.
        function void open_string(logic [4:0] id, logic [7:0] b);
            add(id, 32'(b));
            str_left = b;
            phase = (b != 8'd0) ? sidlp_pkg::PH_STRA : sidlp_pkg::PH_LENB;
        endfunction

        // The fixed part of the wanted descriptor.
        function void decode_fixed(logic [7:0] b);
            logic [31:0] prev;
            prev = acc;
            case (kind)
                sidlp_pkg::KIND_SERVICE:
                begin
                    if (byte_idx == 8'd0) add(sidlp_pkg::FID_SVC_TYPE, 32'(b));
                    else if (byte_idx == 8'd1) open_string(sidlp_pkg::FID_PROV_LEN, b);
                end
                sidlp_pkg::KIND_EVENT:
                begin
                    if (byte_idx == 8'd0) acc = 32'(b);
                    else if (byte_idx <= 8'd2) acc = {prev[23:0], b};
                    if (byte_idx == 8'd2)
                        add(sidlp_pkg::FID_EVENT_LANG, acc & 32'h00FF_FFFF);
                    else if (byte_idx == 8'd3)
                        open_string(sidlp_pkg::FID_EVENT_NLEN, b);
                end
                sidlp_pkg::KIND_NETWORK:
                    add(sidlp_pkg::FID_NET_NAME, 32'(b));
                sidlp_pkg::KIND_SATELLITE:
                begin
                    if (byte_idx == 8'd0 || byte_idx == 8'd4 || byte_idx == 8'd7)
                        acc = 32'(b);
                    else if (byte_idx < 8'd10 && byte_idx != 8'd6)
                        acc = {prev[23:0], b};
                    if (byte_idx == 8'd3) add(sidlp_pkg::FID_FREQUENCY, acc);
                    else if (byte_idx == 8'd5) add(sidlp_pkg::FID_ORBITAL, acc & 32'hFFFF);
                    else if (byte_idx == 8'd6)
                    begin
                        add(sidlp_pkg::FID_WEST_EAST, 32'(b[7]));
                        add(sidlp_pkg::FID_POLARISE, 32'(b[6:5]));
                        add(sidlp_pkg::FID_ROLL_OFF, 32'(b[4:3]));
                        add(sidlp_pkg::FID_MOD_SYSTEM, 32'(b[2]));
                        add(sidlp_pkg::FID_MOD_TYPE, 32'(b[1:0]));
                    end
                    else if (byte_idx == 8'd10)
                    begin
                        add(sidlp_pkg::FID_SYM_RATE, {prev[27:0], b[7:4]} & 32'h0FFF_FFFF);
                        add(sidlp_pkg::FID_FEC_INNER, 32'(b[3:0]));
                    end
                end
                sidlp_pkg::KIND_SVC_LIST:
                begin
                    // Entries of three bytes: service id high, low, then type.
                    if (str_left == 8'd0)
                    begin
                        acc = 32'(b);
                        str_left = 8'd1;
                    end
                    else if (str_left == 8'd1)
                    begin
                        acc = {prev[23:0], b};
                        str_left = 8'd2;
                    end
                    else
                    begin
                        add(sidlp_pkg::FID_LIST_SID, acc & 32'hFFFF);
                        add(sidlp_pkg::FID_LIST_TYPE, 32'(b));
                        if (entries < sidlp_pkg::ENTRY_MAX) entries++;
                        str_left = 8'd0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void parse(logic [7:0] b);
            logic [4:0] base;
            base = (kind == sidlp_pkg::KIND_EVENT) ? sidlp_pkg::FID_EVENT_NLEN
                                                   : sidlp_pkg::FID_PROV_LEN;
            case (phase)
                sidlp_pkg::PH_TAG:
                begin
                    if (kind_tag_hit(b))
                    begin
                        found = 1'b1;
                        add(sidlp_pkg::FID_POSITION, offset);
                        add(sidlp_pkg::FID_TAG, 32'(b));
                    end
                    phase = sidlp_pkg::PH_LEN;
                    return;
                end
                sidlp_pkg::PH_LEN:
                begin
                    desc_len = b;
                    byte_idx = '0;
                    str_left = '0;
                    acc = '0;
                    if (found) add(sidlp_pkg::FID_LENGTH, 32'(b));
                    if (b == 8'd0) phase = found ? sidlp_pkg::PH_DONE : sidlp_pkg::PH_TAG;
                    else phase = found ? sidlp_pkg::PH_FIXED : sidlp_pkg::PH_SKIP;
                    return;
                end
                sidlp_pkg::PH_DONE:
                    return;
                sidlp_pkg::PH_FIXED:
                    decode_fixed(b);
                sidlp_pkg::PH_STRA:
                begin
                    add(base + 5'd1, 32'(b));
                    str_left--;
                    if (str_left == 8'd0) phase = sidlp_pkg::PH_LENB;
                end
                sidlp_pkg::PH_LENB:
                begin
                    add(base + 5'd2, 32'(b));
                    str_left = b;
                    phase = (b != 8'd0) ? sidlp_pkg::PH_STRB : sidlp_pkg::PH_SKIP;
                end
                sidlp_pkg::PH_STRB:
                begin
                    add(base + 5'd3, 32'(b));
                    str_left--;
                    if (str_left == 8'd0) phase = sidlp_pkg::PH_SKIP;
                end
                default: ;
            endcase
            byte_idx++;
            if (byte_idx >= desc_len) phase = found ? sidlp_pkg::PH_DONE : sidlp_pkg::PH_TAG;
        endfunction

        // Note one accepted input item.
        function void note_byte(sidlp_pkg::in_item_t it);
            sidlp_pkg::out_item_t st;
            if (it.loop_start) clear_loop();
            if (offset < MAX_LOOP_BYTES)
            begin
                parse(it.data_byte);
                offset++;
            end
            if (it.loop_end)
            begin
                st.field_id    = sidlp_pkg::FID_STATUS;
                st.field_value = {25'd0, entries};
                st.not_found   = !found;
                st.last_result = 1'b1;
                expected_fields.push_back(st);
                clear_loop();
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        task check_field(sidlp_pkg::out_item_t got);
            sidlp_pkg::out_item_t exp_f;
            checked++;
            if (expected_fields.size() == 0)
            begin
                report($sformatf("unexpected result id %0d value %0h",
                                 got.field_id, got.field_value));
                return;
            end
            exp_f = expected_fields.pop_front();
            if (got.field_id !== exp_f.field_id)
                report($sformatf("field_id %0d, expected %0d", got.field_id, exp_f.field_id));
            if (got.field_value !== exp_f.field_value)
                report($sformatf("field_value %0h, expected %0h (id %0d)",
                                 got.field_value, exp_f.field_value, exp_f.field_id));
            if (got.not_found !== exp_f.not_found)
                report($sformatf("not_found %0b, expected %0b", got.not_found, exp_f.not_found));
            if (got.last_result !== exp_f.last_result)
                report($sformatf("last_result %0b, expected %0b",
                                 got.last_result, exp_f.last_result));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [2:0]           cfg_wr_data;
    logic                 in_valid;
    logic                 in_ready;
    sidlp_pkg::in_item_t  in_item;
    logic                 out_valid;
    logic                 out_ready;
    sidlp_pkg::out_item_t out_item;

    field_scoreboard sb;
    logic [7:0] loop_bytes[$];
    int  items_sent;
    int  loops_sent;
    int  cycles;
    int  hold_left;
    bit  hold_req;
    bit  hold_done;
    bit  pause_done;
    bit  calm;

    si_descriptor_loop_parser #(
        .MAX_LOOP_BYTES(MAX_LOOP_BYTES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one item and hold it until it is taken, then idle now and then.
    task automatic send_byte(logic [7:0] b, logic first, logic last);
        sidlp_pkg::in_item_t it;
        it.data_byte  = b;
        it.loop_start = first;
        it.loop_end   = last;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(it);
        items_sent++;
        if (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Send the collected loop, flagging its first and last byte.
    task automatic send_loop();
        int n;
        n = loop_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(loop_bytes[i], i == 0, i == n - 1);
        loop_bytes.delete();
        loops_sent++;
    endtask

    // Wait until the block has drained, then write the wanted kind.
    task automatic set_kind(logic [2:0] k);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_fields.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        sb.kind = k;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Append one descriptor with a body shaped for the given tag; sometimes the
    // length byte disagrees with the body so that truncation and padding occur.
    task automatic add_descriptor(logic [7:0] tag, bit exact);
        logic [7:0] body[$];
        int n1;
        int n2;
        int len;
        n1 = $urandom_range(0, 5);
        n2 = $urandom_range(0, 5);
        case (tag)
            TAG_SERVICE:
            begin
                body.push_back(8'($urandom));
                body.push_back(8'(n1));
                repeat (n1) body.push_back(8'($urandom));
                body.push_back(8'(n2));
                repeat (n2) body.push_back(8'($urandom));
            end
            TAG_EVENT:
            begin
                repeat (3) body.push_back(8'($urandom));
                body.push_back(8'(n1));
                repeat (n1) body.push_back(8'($urandom));
                body.push_back(8'(n2));
                repeat (n2) body.push_back(8'($urandom));
            end
            TAG_SATELLITE:
                repeat (11 + $urandom_range(0, 2)) body.push_back(8'($urandom));
            TAG_SVC_LIST:
                repeat (3 * $urandom_range(0, 5) + $urandom_range(0, 2))
                    body.push_back(8'($urandom));
            default:
                repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
        endcase
        len = body.size();
        if (!exact && $urandom_range(99) < 20) len = $urandom_range(0, body.size() + 3);
        loop_bytes.push_back(tag);
        loop_bytes.push_back(8'(len));
        for (int i = 0; i < len; i++)
            loop_bytes.push_back(i < body.size() ? body[i] : 8'($urandom));
    endtask

    function automatic logic [7:0] pick_tag(bit want);
        logic [7:0] tags[5];
        tags = '{TAG_SERVICE, TAG_EVENT, TAG_NETWORK, TAG_SATELLITE, TAG_SVC_LIST};
        if (want && sb.kind <= sidlp_pkg::KIND_SVC_LIST) return tags[sb.kind];
        if ($urandom_range(3) == 0) return 8'($urandom);
        return tags[$urandom_range(0, 4)];
    endfunction

    // One random loop: mostly a well-formed chain, sometimes cut short or pure noise.
    task automatic random_loop();
        int nd;
        int cut;
        if ($urandom_range(99) < 6)
        begin
            repeat ($urandom_range(1, 10))
                send_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(5) == 0);
            return;
        end
        nd = $urandom_range(1, 4);
        for (int d = 0; d < nd; d++)
            add_descriptor(pick_tag($urandom_range(99) < 45), 1'b0);
        if ($urandom_range(99) < 10)
        begin
            cut = $urandom_range(1, loop_bytes.size());
            while (loop_bytes.size() > cut) void'(loop_bytes.pop_back());
        end
        send_loop();
    endtask

    // Receiver: check results, stall at random, and hold off on request.
    initial
    begin
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_field(out_item);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
                hold_left--;
            else
                out_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        items_sent  = 0;
        loops_sent  = 0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        calm        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one clean wanted descriptor behind a foreign one, for every kind.
        for (int k = sidlp_pkg::KIND_SERVICE; k <= sidlp_pkg::KIND_SVC_LIST; k++)
        begin
            set_kind(3'(k));
            add_descriptor(8'hFF, 1'b1);
            add_descriptor(pick_tag(1'b1), 1'b1);
            send_loop();
        end

        // A zero-length wanted descriptor, then a one-byte loop.
        loop_bytes = '{TAG_SVC_LIST, 8'd0, TAG_SVC_LIST, 8'd3, 8'hFF, 8'hFF, 8'hFF};
        send_loop();
        send_byte(TAG_SVC_LIST, 1'b1, 1'b1);

        // Unused kinds never match.
        set_kind(3'd7);
        add_descriptor(TAG_SERVICE, 1'b1);
        send_loop();
        set_kind(3'd5);
        add_descriptor(TAG_SVC_LIST, 1'b1);
        send_loop();

        // Random part, with kind changes, a quiet stretch, a long receiver
        // hold-off while the sender keeps going, and a full drain pause.
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(99) < 25)
                set_kind(3'($urandom_range(99) < 8 ? $urandom_range(5, 7)
                                                   : $urandom_range(0, 4)));
            calm = (loops_sent % 12) >= 9;
            if (loops_sent >= HOLD_LOOP && !hold_done)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (loops_sent >= PAUSE_LOOP && !pause_done)
            begin
                pause_done = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.expected_fields.size() != 0) @(posedge clk);
            end
            random_loop();
        end
        in_valid <= 1'b0;

        // Drain.
        while (sb.expected_fields.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("Sent %0d loops and %0d bytes over all wanted kinds and unused kinds;",
                 loops_sent, items_sent);
        $display("checked %0d result items, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_fields.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
